// ===== design/virtual_fat32_sector_mapper_defines.svh =====
`ifndef VIRTUAL_FAT32_SECTOR_MAPPER_DEFINES_SVH
`define VIRTUAL_FAT32_SECTOR_MAPPER_DEFINES_SVH
// Same-cycle implication, checked outside reset.
`define VFSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define VFSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/vfsm_pkg.sv =====
`default_nettype none
package vfsm_pkg;
  localparam int FILE_SLOTS = 64;
  localparam int SLOT_W = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int CNT_W = $clog2(FILE_SLOTS + 1);

  localparam logic [31:0] PART_START = 32'd2048;
  localparam logic [31:0] RESV_SECTORS = 32'd32;
  localparam logic [31:0] ROOT_CLUS = 32'd2;
  localparam logic [31:0] BASE_BLOCKS = 32'd2080;
  localparam logic [29:0] EMPTY_BLOCKS = 30'd2146;
  localparam logic [31:0] MAX_BLOCKS = 32'h3FFF_FFFF;
  localparam logic [31:0] FAT_MEDIA = 32'h0FFF_FFF8;
  localparam logic [31:0] FAT_RSVD = 32'hFFFF_FFFF;
  localparam logic [31:0] FAT_EOC = 32'h0FFF_FFFF;
  localparam logic [31:0] SECT_BYTES = 32'd512;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_MAP    = 2'd2,
    CMD_FAT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ZERO   = 3'd0,
    REG_MBR    = 3'd1,
    REG_BOOT   = 3'd2,
    REG_FSINFO = 3'd3,
    REG_FAT    = 3'd4,
    REG_ROOT   = 3'd5,
    REG_FILE   = 3'd6
  } region_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] file_size;
    logic [31:0] lba;
    logic [31:0] cluster;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [16:0] sector_index;
    logic [5:0]  file_index;
    logic [31:0] byte_offset;
    logic [9:0]  byte_count;
    logic [31:0] fat_value;
    logic [29:0] total_blocks;
    logic        accepted;
  } out_item_t;

  typedef struct packed {
    logic [23:0] first;
    logic [17:0] count;
    logic [31:0] size;
  } entry_t;
endpackage
`default_nettype wire

// ===== design/vfsm_if.sv =====
`default_nettype none
interface vfsm_in_if;
  logic               valid;
  logic               ready;
  vfsm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfsm_out_if;
  logic                valid;
  logic                ready;
  vfsm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/virtual_fat32_sector_mapper.sv =====
// A result passes from the result register to the output register, which is loaded only when it is
// empty or being taken; an owner search checks one table entry per cycle, up to file_count entries.
// Input is accepted again the cycle after the output register is loaded, so a new item is never
// taken while the result of the last one is still on its way to the output register.
// Reset: file count 0, root cluster used, disk size 0; table contents undefined.
`default_nettype none
module virtual_fat32_sector_mapper (
  input  wire         clk,
  input  wire         rst_n,
  vfsm_in_if.sink     in_chan,
  vfsm_out_if.source  out_chan
);
  localparam int SW = vfsm_pkg::SLOT_W;
  localparam int CW = vfsm_pkg::CNT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;

  state_t              state_r;
  logic [SW-1:0]       idx_r;
  logic [31:0]         key_r;
  logic [5:0]          sic_r;
  logic                is_map_r;
  vfsm_pkg::out_item_t res_r;
  vfsm_pkg::out_item_t res_full;
  vfsm_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic [CW-1:0]       file_count_r;
  logic [23:0]         used_r;
  logic [16:0]         fats_r;
  logic [29:0]         disk_r;

  vfsm_pkg::entry_t    mem [vfsm_pkg::FILE_SLOTS];
  vfsm_pkg::entry_t    rdata_r;
  logic [SW-1:0]       raddr;
  logic                mem_we;
  vfsm_pkg::entry_t    wentry;

  vfsm_pkg::in_item_t  in_d;
  logic                accept;
  logic [17:0]         cnt;
  logic [24:0]         used_new;
  logic [25:0]         used_p2;
  logic [19:0]         fats_new;
  logic [31:0]         blocks_new;
  logic                fits;
  logic [31:0]         rel, fat1, data0, drel, clus_c;
  logic                in_disk;
  logic                last;
  logic                hit;
  logic [31:0]         diff, off, rem;
  logic [32:0]         diff_p1;

  assign in_d = in_chan.data;
  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data = out_r;

  // Append geometry: clusters rounded up, FAT sectors rounded up to 128 entries each.
  always_comb begin
    cnt = {1'b0, in_d.file_size[31:15]} + {17'd0, |in_d.file_size[14:0]};
    if (cnt == 18'd0) begin
      cnt = 18'd1;
    end
    used_new = {1'b0, used_r} + {7'd0, cnt};
    used_p2 = {1'b0, used_new} + 26'd2;
    fats_new = {1'b0, used_p2[25:7]} + {19'd0, |used_p2[6:0]};
    blocks_new = vfsm_pkg::BASE_BLOCKS + {11'd0, fats_new, 1'b0} + {1'b0, used_new, 6'd0};
    fits = (file_count_r != CW'(vfsm_pkg::FILE_SLOTS)) && (blocks_new <= vfsm_pkg::MAX_BLOCKS);
    mem_we = accept && (in_d.command == vfsm_pkg::CMD_APPEND) && fits;
    wentry.first = 24'(used_r + 24'd2);
    wentry.count = cnt;
    wentry.size = in_d.file_size;
  end

  // Sector geometry.
  always_comb begin
    in_disk = (in_d.lba >= vfsm_pkg::PART_START) && (in_d.lba < {2'b00, disk_r});
    rel = in_d.lba - vfsm_pkg::PART_START;
    fat1 = vfsm_pkg::RESV_SECTORS + {15'd0, fats_r};
    data0 = fat1 + {15'd0, fats_r};
    drel = rel - data0;
    clus_c = vfsm_pkg::ROOT_CLUS + {6'd0, drel[31:6]};
  end

  // Owner check of the entry read in the previous cycle.
  always_comb begin
    last = (CW'(idx_r) + CW'(1)) == file_count_r;
    hit = (key_r >= {8'd0, rdata_r.first}) &&
          (key_r < ({8'd0, rdata_r.first} + {14'd0, rdata_r.count}));
    diff = key_r - {8'd0, rdata_r.first};
    off = {diff[16:0], 15'd0} + {17'd0, sic_r, 9'd0};
    rem = rdata_r.size - off;
    diff_p1 = {1'b0, diff} + 33'd1;
    raddr = (state_r == ST_IDLE) ? '0 : SW'(idx_r + SW'(1));
  end

  always_comb begin
    res_full = res_r;
    res_full.total_blocks = disk_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[file_count_r[SW-1:0]] <= wentry;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      res_r <= '0;
      file_count_r <= '0;
      used_r <= 24'd1;
      fats_r <= 17'd1;
      disk_r <= 30'd0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            idx_r <= '0;
            state_r <= ST_OUT;
            unique case (vfsm_pkg::cmd_t'(in_d.command))
              vfsm_pkg::CMD_CLEAR: begin
                file_count_r <= '0;
                used_r <= 24'd1;
                fats_r <= 17'd1;
                disk_r <= vfsm_pkg::EMPTY_BLOCKS;
              end
              vfsm_pkg::CMD_APPEND: begin
                if (fits) begin
                  file_count_r <= file_count_r + CW'(1);
                  used_r <= used_new[23:0];
                  fats_r <= fats_new[16:0];
                  disk_r <= blocks_new[29:0];
                  res_r.accepted <= 1'b1;
                end
              end
              vfsm_pkg::CMD_MAP: begin
                is_map_r <= 1'b1;
                key_r <= clus_c;
                sic_r <= drel[5:0];
                priority if (in_d.lba == 32'd0) begin
                  res_r.region <= vfsm_pkg::REG_MBR;
                end else if (!in_disk) begin
                  res_r.region <= vfsm_pkg::REG_ZERO;
                end else if (rel == 32'd0 || rel == 32'd6) begin
                  res_r.region <= vfsm_pkg::REG_BOOT;
                end else if (rel == 32'd1 || rel == 32'd7) begin
                  res_r.region <= vfsm_pkg::REG_FSINFO;
                end else if (rel < vfsm_pkg::RESV_SECTORS) begin
                  res_r.region <= vfsm_pkg::REG_ZERO;
                end else if (rel < fat1) begin
                  res_r.region <= vfsm_pkg::REG_FAT;
                  res_r.sector_index <= 17'(rel - vfsm_pkg::RESV_SECTORS);
                end else if (rel < data0) begin
                  res_r.region <= vfsm_pkg::REG_FAT;
                  res_r.sector_index <= 17'(rel - fat1);
                end else if (clus_c == vfsm_pkg::ROOT_CLUS) begin
                  res_r.region <= vfsm_pkg::REG_ROOT;
                  res_r.sector_index <= {11'd0, drel[5:0]};
                end else if (file_count_r != '0) begin
                  state_r <= ST_SCAN;
                end
              end
              vfsm_pkg::CMD_FAT: begin
                is_map_r <= 1'b0;
                key_r <= in_d.cluster;
                sic_r <= '0;
                priority if (in_d.cluster == 32'd0) begin
                  res_r.fat_value <= vfsm_pkg::FAT_MEDIA;
                end else if (in_d.cluster == 32'd1) begin
                  res_r.fat_value <= vfsm_pkg::FAT_RSVD;
                end else if (in_d.cluster == vfsm_pkg::ROOT_CLUS) begin
                  res_r.fat_value <= vfsm_pkg::FAT_EOC;
                end else if (file_count_r != '0) begin
                  state_r <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (hit) begin
            state_r <= ST_OUT;
            if (is_map_r) begin
              res_r.region <= vfsm_pkg::REG_FILE;
              res_r.file_index <= 6'(idx_r);
              res_r.byte_offset <= off;
              if (rdata_r.size > off) begin
                res_r.byte_count <= (rem > vfsm_pkg::SECT_BYTES) ? 10'd512 : rem[9:0];
              end
            end else begin
              res_r.fat_value <= (diff_p1 >= {15'd0, rdata_r.count}) ?
                                 vfsm_pkg::FAT_EOC : 32'(key_r + 32'd1);
            end
          end else if (last) begin
            state_r <= ST_OUT;
          end else begin
            idx_r <= SW'(idx_r + SW'(1));
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_r <= res_full;
            res_r <= '0;
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/vfsm_chk.sv =====
`default_nettype none
`include "virtual_fat32_sector_mapper_defines.svh"
module vfsm_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_region,
  input wire [5:0]  out_file_index,
  input wire [31:0] out_byte_offset,
  input wire [9:0]  out_byte_count,
  input wire [31:0] out_fat_value,
  input wire [29:0] out_total_blocks,
  input wire        out_accepted
);
  `VFSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `VFSM_ASSERT_NOW(a_count_max, out_valid, out_byte_count <= 10'd512, "byte count above a sector")
  `VFSM_ASSERT_NOW(a_nonfile_clean, out_valid && out_region != 3'(vfsm_pkg::REG_FILE), out_byte_count == 10'd0 && out_file_index == 6'd0 && out_byte_offset == 32'd0, "file fields set outside file data")
  `VFSM_ASSERT_NOW(a_append_result, out_valid && out_accepted, out_region == 3'(vfsm_pkg::REG_ZERO) && out_fat_value == 32'd0 && out_total_blocks >= vfsm_pkg::EMPTY_BLOCKS, "accepted append with odd result")
endmodule

bind virtual_fat32_sector_mapper vfsm_chk u_vfsm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_region       (out_chan.data.region),
  .out_file_index   (out_chan.data.file_index),
  .out_byte_offset  (out_chan.data.byte_offset),
  .out_byte_count   (out_chan.data.byte_count),
  .out_fat_value    (out_chan.data.fat_value),
  .out_total_blocks (out_chan.data.total_blocks),
  .out_accepted     (out_chan.data.accepted)
);
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  vfsm_in_if in_if ();
  vfsm_out_if out_if ();

  virtual_fat32_sector_mapper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow of the block's file table and volume geometry.
  logic [23:0] first_clus_q [vfsm_pkg::FILE_SLOTS];
  logic [17:0] clus_cnt_q [vfsm_pkg::FILE_SLOTS];
  logic [31:0] size_q [vfsm_pkg::FILE_SLOTS];
  int unsigned files_held = 0;
  longint unsigned clusters_used = 1;
  longint unsigned fat_secs = 1;
  logic [29:0] volume_blocks = '0;

  vfsm_pkg::in_item_t cmd_queue[$];
  vfsm_pkg::out_item_t awaited_results[$];
  int unsigned items_sent = 0;
  int unsigned items_seen = 0;
  int unsigned items_pushed = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic longint unsigned fat_secs_for(longint unsigned used);
    return ((64'd2 + used) * 64'd4 + 64'd511) / 64'd512;
  endfunction

  function automatic longint unsigned blocks_for(longint unsigned used,
                                                 longint unsigned fats);
    return 64'd2080 + 64'd2 * fats + used * 64'd64;
  endfunction

  function automatic int owner_of(logic [31:0] clus);
    longint unsigned lo;
    for (int i = 0; i < files_held; i++) begin
      lo = first_clus_q[i];
      if (longint'(clus) >= lo && longint'(clus) < lo + clus_cnt_q[i]) return i;
    end
    return -1;
  endfunction

  function automatic vfsm_pkg::out_item_t map_and_update(vfsm_pkg::in_item_t it);
    vfsm_pkg::out_item_t r;
    longint unsigned cnt, used, fats, blks, off, sz;
    logic [31:0] rel, fat1, data0, drel, c, sic, coff;
    int f;
    r = '0;
    case (vfsm_pkg::cmd_t'(it.command))
      vfsm_pkg::CMD_CLEAR: begin
        files_held = 0;
        clusters_used = 1;
        fat_secs = fat_secs_for(1);
        volume_blocks = 30'(blocks_for(1, fat_secs));
      end
      vfsm_pkg::CMD_APPEND: begin
        if (files_held < vfsm_pkg::FILE_SLOTS) begin
          cnt = (longint'(it.file_size) + 64'd32767) / 64'd32768;
          if (cnt == 0) cnt = 1;
          used = clusters_used + cnt;
          fats = fat_secs_for(used);
          blks = blocks_for(used, fats);
          if (blks <= 64'h3FFF_FFFF) begin
            first_clus_q[files_held] = 24'(64'd2 + clusters_used);
            clus_cnt_q[files_held] = 18'(cnt);
            size_q[files_held] = it.file_size;
            files_held++;
            clusters_used = used;
            fat_secs = fats;
            volume_blocks = 30'(blks);
            r.accepted = 1'b1;
          end
        end
      end
      vfsm_pkg::CMD_MAP: begin
        if (it.lba == 0) begin
          r.region = vfsm_pkg::REG_MBR;
        end else if (it.lba >= vfsm_pkg::PART_START && it.lba < {2'b00, volume_blocks}) begin
          rel = it.lba - vfsm_pkg::PART_START;
          fat1 = vfsm_pkg::RESV_SECTORS + 32'(fat_secs);
          data0 = fat1 + 32'(fat_secs);
          if (rel == 0 || rel == 6) begin
            r.region = vfsm_pkg::REG_BOOT;
          end else if (rel == 1 || rel == 7) begin
            r.region = vfsm_pkg::REG_FSINFO;
          end else if (rel < vfsm_pkg::RESV_SECTORS) begin
            r.region = vfsm_pkg::REG_ZERO;
          end else if (rel < fat1) begin
            r.region = vfsm_pkg::REG_FAT;
            r.sector_index = 17'(rel - vfsm_pkg::RESV_SECTORS);
          end else if (rel < data0) begin
            r.region = vfsm_pkg::REG_FAT;
            r.sector_index = 17'(rel - fat1);
          end else begin
            drel = rel - data0;
            c = vfsm_pkg::ROOT_CLUS + drel / 64;
            sic = drel % 64;
            if (c == vfsm_pkg::ROOT_CLUS) begin
              r.region = vfsm_pkg::REG_ROOT;
              r.sector_index = 17'(sic);
            end else begin
              f = owner_of(c);
              if (f >= 0) begin
                off = longint'(c - {8'd0, first_clus_q[f]}) * 64'd32768
                      + longint'(sic) * 64'd512;
                sz = size_q[f];
                r.region = vfsm_pkg::REG_FILE;
                r.file_index = 6'(f);
                r.byte_offset = 32'(off);
                if (off < sz) r.byte_count = (sz - off > 512) ? 10'd512 : 10'(sz - off);
              end
            end
          end
        end
      end
      default: begin
        if (it.cluster == 0) begin
          r.fat_value = vfsm_pkg::FAT_MEDIA;
        end else if (it.cluster == 1) begin
          r.fat_value = vfsm_pkg::FAT_RSVD;
        end else if (it.cluster == vfsm_pkg::ROOT_CLUS) begin
          r.fat_value = vfsm_pkg::FAT_EOC;
        end else begin
          f = owner_of(it.cluster);
          if (f >= 0) begin
            coff = it.cluster - {8'd0, first_clus_q[f]};
            r.fat_value = (coff + 32'd1 >= {14'd0, clus_cnt_q[f]}) ? vfsm_pkg::FAT_EOC
                                                                   : it.cluster + 32'd1;
          end
        end
      end
    endcase
    r.total_blocks = volume_blocks;
    return r;
  endfunction

  // Sender: one item on the wire at a time, with a random gap after each one is taken.
  int unsigned send_gap;
  logic send_quiet;
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      send_gap <= 0;
      send_quiet <= 1'b0;
    end else begin
      nv = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        awaited_results.push_back(map_and_update(in_if.data));
        items_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (cmd_queue.size() > 0) begin
          in_if.data <= cmd_queue.pop_front();
          nv = 1'b1;
          send_gap <= send_quiet ? 0 : $urandom_range(0, 10);
          if ($urandom_range(0, 59) == 0) send_quiet <= ~send_quiet;
        end
      end
      in_if.valid <= nv;
    end
  end

  // A single long hold-off on the result side, so the block backs up.
  int unsigned hold_left;
  logic hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_sent >= 600) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch in %s: expected %h, got %h", name, want, got);
  endtask

  int unsigned recv_stall;
  logic recv_quiet;
  always @(posedge clk) begin
    logic nr;
    vfsm_pkg::out_item_t want, got;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
      recv_quiet <= 1'b0;
    end else begin
      nr = out_if.ready;
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        items_seen++;
        if (awaited_results.size() == 0) begin
          if (mismatches < 10) $display("result with nothing outstanding: %h", got);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (want != got) begin
            if (want.region != got.region)
              report_field("region", 32'(want.region), 32'(got.region));
            if (want.sector_index != got.sector_index)
              report_field("sector_index", 32'(want.sector_index), 32'(got.sector_index));
            if (want.file_index != got.file_index)
              report_field("file_index", 32'(want.file_index), 32'(got.file_index));
            if (want.byte_offset != got.byte_offset)
              report_field("byte_offset", want.byte_offset, got.byte_offset);
            if (want.byte_count != got.byte_count)
              report_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
            if (want.fat_value != got.fat_value)
              report_field("fat_value", want.fat_value, got.fat_value);
            if (want.total_blocks != got.total_blocks)
              report_field("total_blocks", 32'(want.total_blocks), 32'(got.total_blocks));
            if (want.accepted != got.accepted)
              report_field("accepted", 32'(want.accepted), 32'(got.accepted));
            mismatches++;
          end
        end
        nr = 1'b0;
        recv_stall <= recv_quiet ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 59) == 0) recv_quiet <= ~recv_quiet;
      end else if (!nr) begin
        if (recv_stall > 0) recv_stall <= recv_stall - 1;
        else if (hold_left == 0) nr = 1'b1;
      end
      out_if.ready <= nr;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_cmd(vfsm_pkg::cmd_t op, logic [31:0] value);
    vfsm_pkg::in_item_t it;
    it.command = op;
    it.file_size = $urandom();
    it.lba = $urandom();
    it.cluster = $urandom();
    case (op)
      vfsm_pkg::CMD_APPEND: it.file_size = value;
      vfsm_pkg::CMD_MAP: it.lba = value;
      vfsm_pkg::CMD_FAT: it.cluster = value;
      default: ;
    endcase
    cmd_queue.push_back(it);
    items_pushed++;
  endtask

  // Picks a sector address, mostly inside the volume as it currently stands.
  function automatic logic [31:0] pick_lba();
    logic [31:0] top, data0;
    int f;
    top = {2'b00, volume_blocks};
    data0 = vfsm_pkg::PART_START + vfsm_pkg::RESV_SECTORS + 32'(2 * fat_secs);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 2047);
      2: return vfsm_pkg::PART_START + $urandom_range(0, 40);
      3: return (top > 0) ? top - $urandom_range(0, 2) : 32'd0;
      4, 5: return (top > data0) ? $urandom_range(data0, top - 1) : $urandom_range(0, 2500);
      default: begin
        if (files_held == 0) return data0 + $urandom_range(0, 200);
        f = $urandom_range(0, files_held - 1);
        return data0 + (first_clus_q[f] - 2 + $urandom_range(0, clus_cnt_q[f])) * 64
               + $urandom_range(0, 63);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_cluster();
    int f;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3);
      default: begin
        if (files_held == 0) return $urandom_range(0, 20);
        f = $urandom_range(0, files_held - 1);
        return first_clus_q[f] + $urandom_range(0, clus_cnt_q[f]);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32768 * $urandom_range(0, 8) + $urandom_range(0, 2) - 1;
      2: return $urandom_range(0, 600);
      default: return $urandom_range(0, 300000);
    endcase
  endfunction

  initial begin
    int unsigned made, appends;
    logic [31:0] probes [16];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Straight after reset the volume has no size, so only sector 0 maps.
    push_cmd(vfsm_pkg::CMD_MAP, 32'd0);
    push_cmd(vfsm_pkg::CMD_MAP, 32'd2048);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd0);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd1);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd2);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd3);
    push_cmd(vfsm_pkg::CMD_CLEAR, 32'd0);
    push_cmd(vfsm_pkg::CMD_APPEND, 32'd0);
    push_cmd(vfsm_pkg::CMD_APPEND, 32'd1);
    push_cmd(vfsm_pkg::CMD_APPEND, 32'd32768);
    push_cmd(vfsm_pkg::CMD_APPEND, 32'd32769);
    // Boot copies, FS info copies, reserved fill, both FATs, root and each file.
    probes = '{32'd2048, 32'd2054, 32'd2049, 32'd2055, 32'd2050, 32'd2080, 32'd2081,
               32'd2082, 32'd2145, 32'd2146, 32'd2210, 32'd2274, 32'd2402, 32'd2465,
               32'd2466, 32'd5};
    foreach (probes[i])
      push_cmd(vfsm_pkg::CMD_MAP, probes[i]);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd6);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd7);
    push_cmd(vfsm_pkg::CMD_FAT, 32'd8);
    push_cmd(vfsm_pkg::CMD_APPEND, 32'hFFFF_FFFF);
    push_cmd(vfsm_pkg::CMD_MAP, 32'hFFFF_FFFF);

    // Random part: a clear, a burst of appends (sometimes past a full table),
    // then lookups aimed at what the table now holds.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      while (cmd_queue.size() > 2) @(posedge clk);
      case ($urandom_range(0, 19))
        0: begin
          push_cmd(vfsm_pkg::CMD_CLEAR, 32'd0);
          made++;
          appends = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 12);
          repeat (appends) push_cmd(vfsm_pkg::CMD_APPEND, pick_size());
          made += appends;
        end
        1, 2: begin
          push_cmd(vfsm_pkg::CMD_APPEND, pick_size());
          made++;
        end
        3, 4, 5, 6, 7: begin
          push_cmd(vfsm_pkg::CMD_FAT, pick_cluster());
          made++;
        end
        default: begin
          push_cmd(vfsm_pkg::CMD_MAP, pick_lba());
          made++;
        end
      endcase
    end

    // Every queued item must come back as a result before the verdict.
    while (items_seen < items_pushed)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/vfsm_pkg.sv
design/vfsm_if.sv
design/virtual_fat32_sector_mapper.sv
design/vfsm_chk.sv
test/testbench.sv
